[rtl/dpbp_pkg.sv]
// shared types, register indexes and constants for the depth back-projection core
package dpbp_pkg;

    localparam int MAX_COLUMNS = 4096;
    localparam int MAX_ROWS    = 4096;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_COL    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_ROW    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_FOCAL_COL = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_FOCAL_ROW = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_MIN       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_MAX       = 3'd5;

    localparam logic [15:0] RST_CENTER_COL = 16'd5120;
    localparam logic [15:0] RST_CENTER_ROW = 16'd3840;
    localparam logic [23:0] RST_INV_FOCAL  = 24'd32263;
    localparam logic [47:0] RST_BOX_MIN    = 48'hEC14_EC14_EC14;
    localparam logic [47:0] RST_BOX_MAX    = 48'h13EC_13EC_13EC;

    // signed position before saturation, 1/16 mm
    localparam int POS_W = 34;

    // pipeline stages ahead of the box stage
    localparam int AXIS_STAGES = 4;

    typedef struct packed {
        logic [11:0] pixel_col;
        logic [11:0] pixel_row;
        logic [15:0] depth_mm;
        logic        mask_bit;
        logic [7:0]  red_in;
        logic [7:0]  green_in;
        logic [7:0]  blue_in;
    } t_pixel_in;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic [15:0]        pos_z;
        logic [7:0]         red_out;
        logic [7:0]         green_out;
        logic [7:0]         blue_out;
        logic               point_valid;
        logic               keep_point;
    } t_point_out;

    // data that rides alongside the projection stages
    typedef struct packed {
        logic        point_valid;
        logic        mask_bit;
        logic [15:0] depth_mm;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
    } t_side;

endpackage

[rtl/dpbp_axis.sv]
// four-stage projection of one axis: offset, depth product, focal product, rounding
module dpbp_axis (
    input  logic                                i_clk,
    input  logic [11:0]                         i_pix,
    input  logic [15:0]                         i_center,
    input  logic [15:0]                         i_depth,
    input  logic [23:0]                         i_inv_focal,
    output logic signed [dpbp_pkg::POS_W-1:0]   o_pos
);
    import dpbp_pkg::*;

    logic signed [16:0] diff;
    logic [15:0]        mag;
    logic [56:0]        rounded;
    logic [32:0]        quot;

    logic [15:0]              r_mag_a;
    logic                     r_neg_a;
    logic [15:0]              r_depth_a;
    logic [31:0]              r_md_b;
    logic                     r_neg_b;
    logic [55:0]              r_prod_c;
    logic                     r_neg_c;
    logic signed [POS_W-1:0]  r_pos_d;

    logic [15:0]              n_mag_a;
    logic [31:0]              n_md_b;
    logic [55:0]              n_prod_c;
    logic signed [POS_W-1:0]  n_pos_d;

    always_comb begin
        diff    = $signed({1'b0, i_pix, 4'b0000}) - $signed({1'b0, i_center});
        mag     = diff[16] ? 16'(-diff) : diff[15:0];
        n_mag_a = mag;
        n_md_b  = 32'(r_mag_a) * 32'(r_depth_a);
        n_prod_c = 56'(r_md_b) * 56'(i_inv_focal);
        // round half away from zero on the magnitude
        rounded = 57'(r_prod_c) + 57'(1 << 23);
        quot    = rounded[56:24];
        n_pos_d = r_neg_c ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
    end

    always_ff @(posedge i_clk) begin
        r_mag_a   <= n_mag_a;
        r_neg_a   <= diff[16];
        r_depth_a <= i_depth;
        r_md_b    <= n_md_b;
        r_neg_b   <= r_neg_a;
        r_prod_c  <= n_prod_c;
        r_neg_c   <= r_neg_b;
        r_pos_d   <= n_pos_d;
    end

    assign o_pos = r_pos_d;

endmodule

[rtl/dpbp_box.sv]
// last stage: saturation, inclusive box test and result register
module dpbp_box (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  dpbp_pkg::t_side                     i_side,
    input  logic signed [dpbp_pkg::POS_W-1:0]   i_pos_x,
    input  logic signed [dpbp_pkg::POS_W-1:0]   i_pos_y,
    input  logic [47:0]                         i_box_min,
    input  logic [47:0]                         i_box_max,
    output logic                                o_valid,
    output dpbp_pkg::t_point_out                o_result
);
    import dpbp_pkg::*;

    localparam logic signed [POS_W-1:0] SAT_MAX = POS_W'(64'sd2147483647);
    localparam logic signed [POS_W-1:0] SAT_MIN = -POS_W'(64'sd2147483648);

    logic signed [POS_W-1:0] lo_x, hi_x, lo_y, hi_y;
    logic signed [16:0]      lo_z, hi_z, pz;
    logic                    in_box;
    logic signed [31:0]      sat_x, sat_y;

    logic       r_valid;
    t_point_out r_result;
    t_point_out n_result;

    function automatic logic signed [31:0] sat32(input logic signed [POS_W-1:0] v);
        logic signed [31:0] res;
        if (v > SAT_MAX) begin
            res = 32'sh7FFF_FFFF;
        end else if (v < SAT_MIN) begin
            res = 32'sh8000_0000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

    always_comb begin
        // x and y bounds scaled from mm to 1/16 mm
        lo_x = POS_W'($signed({i_box_min[15:0], 4'b0000}));
        hi_x = POS_W'($signed({i_box_max[15:0], 4'b0000}));
        lo_y = POS_W'($signed({i_box_min[31:16], 4'b0000}));
        hi_y = POS_W'($signed({i_box_max[31:16], 4'b0000}));
        lo_z = 17'($signed(i_box_min[47:32]));
        hi_z = 17'($signed(i_box_max[47:32]));
        pz   = $signed({1'b0, i_side.depth_mm});
        in_box = (i_pos_x >= lo_x) && (i_pos_x <= hi_x) &&
                 (i_pos_y >= lo_y) && (i_pos_y <= hi_y) &&
                 (pz >= lo_z) && (pz <= hi_z);
        sat_x = sat32(i_pos_x);
        sat_y = sat32(i_pos_y);

        n_result.red_out     = i_side.red;
        n_result.green_out   = i_side.green;
        n_result.blue_out    = i_side.blue;
        n_result.point_valid = i_side.point_valid;
        if (i_side.point_valid) begin
            n_result.pos_x      = sat_x;
            n_result.pos_y      = sat_y;
            n_result.pos_z      = i_side.depth_mm;
            n_result.keep_point = i_side.mask_bit & in_box;
        end else begin
            n_result.pos_x      = '0;
            n_result.pos_y      = '0;
            n_result.pos_z      = '0;
            n_result.keep_point = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

[rtl/depth_pixel_backprojection_box_filter_core.sv]
// depth pixel back-projection with box filter: each item runs through the stages below from start to its o_valid strobe
// throughput one item per cycle; busy is always low and a new item may start every cycle
// stages: offset, depth product, focal product, rounding, saturation and box test
// o_valid marks each result for one cycle; the receiver cannot stall the pipeline
// synchronous active-low reset clears valid bits and loads default camera and box settings
module depth_pixel_backprojection_box_filter_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  dpbp_pkg::t_pixel_in                 i_pixel,
    output logic                                o_valid,
    output dpbp_pkg::t_point_out                o_result,
    input  logic                                i_cfg_we,
    input  logic [dpbp_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [dpbp_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import dpbp_pkg::*;

    logic [15:0] r_center_col;
    logic [15:0] r_center_row;
    logic [23:0] r_inv_focal_col;
    logic [23:0] r_inv_focal_row;
    logic [47:0] r_box_min;
    logic [47:0] r_box_max;

    logic [AXIS_STAGES-1:0] r_vld;
    t_side                  r_side [AXIS_STAGES];
    t_side                  n_side;
    logic                   accept;

    logic signed [POS_W-1:0] pos_x, pos_y;

    assign busy   = 1'b0;
    assign accept = start & ~busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_col    <= RST_CENTER_COL;
            r_center_row    <= RST_CENTER_ROW;
            r_inv_focal_col <= RST_INV_FOCAL;
            r_inv_focal_row <= RST_INV_FOCAL;
            r_box_min       <= RST_BOX_MIN;
            r_box_max       <= RST_BOX_MAX;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_CENTER_COL:    r_center_col    <= i_cfg_data[15:0];
                CFG_CENTER_ROW:    r_center_row    <= i_cfg_data[15:0];
                CFG_INV_FOCAL_COL: r_inv_focal_col <= i_cfg_data[23:0];
                CFG_INV_FOCAL_ROW: r_inv_focal_row <= i_cfg_data[23:0];
                CFG_BOX_MIN:       r_box_min       <= i_cfg_data[47:0];
                CFG_BOX_MAX:       r_box_max       <= i_cfg_data[47:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_side.point_valid = (i_pixel.depth_mm != 16'd0) &&
                             (32'(i_pixel.pixel_col) < MAX_COLUMNS) &&
                             (32'(i_pixel.pixel_row) < MAX_ROWS);
        n_side.mask_bit    = i_pixel.mask_bit;
        n_side.depth_mm    = i_pixel.depth_mm;
        n_side.red         = i_pixel.red_in;
        n_side.green       = i_pixel.green_in;
        n_side.blue        = i_pixel.blue_in;
    end

    // item valid bits and sideband travel in step with the axis stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[AXIS_STAGES-2:0], accept};
        end
    end

    always_ff @(posedge i_clk) begin
        r_side[0] <= n_side;
        for (int i = 1; i < AXIS_STAGES; i++) begin
            r_side[i] <= r_side[i-1];
        end
    end

    dpbp_axis u_axis_x (
        .i_clk       (i_clk),
        .i_pix       (i_pixel.pixel_col),
        .i_center    (r_center_col),
        .i_depth     (i_pixel.depth_mm),
        .i_inv_focal (r_inv_focal_col),
        .o_pos       (pos_x)
    );

    dpbp_axis u_axis_y (
        .i_clk       (i_clk),
        .i_pix       (i_pixel.pixel_row),
        .i_center    (r_center_row),
        .i_depth     (i_pixel.depth_mm),
        .i_inv_focal (r_inv_focal_row),
        .o_pos       (pos_y)
    );

    dpbp_box u_box (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (r_vld[AXIS_STAGES-1]),
        .i_side    (r_side[AXIS_STAGES-1]),
        .i_pos_x   (pos_x),
        .i_pos_y   (pos_y),
        .i_box_min (r_box_min),
        .i_box_max (r_box_max),
        .o_valid   (o_valid),
        .o_result  (o_result)
    );

endmodule
